@@ rtl/adnp_pkg.sv @@
`timescale 1ns / 1ps

package adnp_pkg;

  localparam int ACC_W  = 53;
  localparam int FRAC_W = 7;
  localparam int MANT_W = ACC_W + 1;
  localparam int PROD_W = ACC_W + 4;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [FRAC_W-1:0] frac;
    logic              digit_seen;
    logic              point_seen;
    logic              negative;
    logic              saturated;
  } adnp_tok_t;

  typedef struct packed {
    logic              emit;
    logic [ACC_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
    logic              ok;
    logic              ovf;
    logic              neg;
    logic              line_end;
  } adnp_res_t;

endpackage

@@ rtl/adnp_core.sv @@
`timescale 1ns / 1ps

module adnp_core #(
  parameter int LINE_LENGTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         char_code,
  output adnp_pkg::adnp_res_t res
);
  import adnp_pkg::*;

  localparam int POS_W = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;

  adnp_tok_t        tok;
  adnp_tok_t        tok_upd;
  adnp_tok_t        tok_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W:0]   pos_inc;
  logic [3:0]       digit;
  logic [PROD_W-1:0] prod;
  logic             is_digit;
  logic             stop;
  logic             line_done;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = 4'(char_code - CH_ZERO);
  assign prod     = {1'b0, tok.acc, 3'b000} + {2'b00, tok.acc, 1'b0}
                  + {{(PROD_W - 4){1'b0}}, digit};
  assign pos_inc  = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    tok_upd   = tok;
    stop      = 1'b0;
    line_done = 1'b0;
    if (is_digit) begin
      tok_upd.digit_seen = 1'b1;
      if (|prod[PROD_W-1:ACC_W]) begin
        tok_upd.acc       = ACC_MAX;
        tok_upd.saturated = 1'b1;
      end else begin
        tok_upd.acc = prod[ACC_W-1:0];
      end
      if (tok.point_seen && (tok.frac != FRAC_MAX)) begin
        tok_upd.frac = tok.frac + 1'b1;
      end
    end else if (char_code == CH_POINT) begin
      tok_upd.point_seen = 1'b1;
      tok_upd.frac       = '0;
    end else if (char_code == CH_NUL) begin
      stop      = 1'b1;
      line_done = 1'b1;
    end else if (char_code == CH_MINUS) begin
      if (tok.digit_seen) begin
        tok_upd.digit_seen = 1'b0;
      end else begin
        tok_upd.negative = 1'b1;
      end
    end else if ((char_code == CH_SPACE) || (char_code == CH_TAB)) begin
      stop = tok.digit_seen;
    end else begin
      tok_upd.digit_seen = 1'b0;
      stop               = 1'b1;
    end

    if (pos_inc >= (POS_W + 1)'(LINE_LENGTH)) begin
      stop      = 1'b1;
      line_done = 1'b1;
    end
    pos_next = line_done ? '0 : pos_inc[POS_W-1:0];
    tok_next = stop ? '0 : tok_upd;

    res.emit     = stop;
    res.ok       = tok_upd.digit_seen;
    res.mag      = tok_upd.digit_seen ? tok_upd.acc : '0;
    res.frac     = tok_upd.digit_seen ? tok_upd.frac : '0;
    res.ovf      = tok_upd.digit_seen & tok_upd.saturated;
    res.neg      = tok_upd.digit_seen & tok_upd.negative;
    res.line_end = line_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
      pos <= '0;
    end else if (step) begin
      tok <= tok_next;
      pos <= pos_next;
    end
  end

  a_line_end_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (step && res.emit && res.line_end) |=> (pos == '0))
    else $error("Line position not cleared after line end.");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (rst)
    tok.saturated |-> (tok.acc == ACC_MAX))
    else $error("Saturated flag set without a saturated accumulator.");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    (step && res.emit && !res.ok) |-> ((res.mag == '0) && (res.frac == '0) && !res.ovf))
    else $error("Failed token carries a nonzero result.");

endmodule

@@ rtl/adnp_out.sv @@
`timescale 1ns / 1ps

module adnp_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  adnp_pkg::adnp_res_t          res,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [adnp_pkg::MANT_W-1:0] mantissa,
  output logic [adnp_pkg::FRAC_W-1:0]  fraction_digits,
  output logic                         ok,
  output logic                         overflow,
  output logic                         line_end
);
  import adnp_pkg::*;

  logic [ACC_W-1:0]  mag;
  logic [FRAC_W-1:0] frac;
  logic              neg;
  logic [MANT_W-1:0] mag_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag      <= res.mag;
      frac     <= res.frac;
      ok       <= res.ok;
      overflow <= res.ovf;
      neg      <= res.neg;
      line_end <= res.line_end;
    end
  end

  assign mag_ext         = {1'b0, mag};
  assign mantissa        = neg ? $signed(-mag_ext) : $signed(mag_ext);
  assign fraction_digits = frac;

endmodule

@@ rtl/ascii_decimal_number_parser_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    char_code
// out      source     out_valid / out_stall  mantissa, fraction_digits, ok, overflow, line_end
//
// One character per cycle unless the output stalls; the digit update is a shift-and-add.
// The character register feeds the core, whose result is registered in the output stage.
// Reset clears the token state, the line position and both valid flags.
// A stall on a valid output holds the character register, which then stalls the input.
module ascii_decimal_number_parser_top #(
  parameter int LINE_LENGTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          char_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adnp_pkg::MANT_W-1:0]  mantissa,
  output logic [adnp_pkg::FRAC_W-1:0]         fraction_digits,
  output logic                                ok,
  output logic                                overflow,
  output logic                                line_end
);
  import adnp_pkg::*;

  logic       char_valid;
  logic [7:0] char_q;
  logic       step;
  logic       accept;
  adnp_res_t  res;

  assign step     = char_valid && (!out_valid || !out_stall);
  assign in_stall = char_valid && !step;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (accept) begin
      char_valid <= 1'b1;
    end else if (step) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_q <= char_code;
    end
  end

  adnp_core #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .char_code(char_q),
    .res      (res)
  );

  adnp_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (step && res.emit),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .mantissa       (mantissa),
    .fraction_digits(fraction_digits),
    .ok             (ok),
    .overflow       (overflow),
    .line_end       (line_end)
  );

endmodule
